[design/mtvb_pkg.sv]
// Shared constants, state codes and control structures of the morph target vertex blender.
package mtvb_pkg;

   localparam int TARGET_COUNT = 12;
   localparam int IDX_W        = $clog2(TARGET_COUNT);
   localparam int WSUM_W       = 16 + IDX_W + 1;
   localparam int TGT_W        = 4;
   localparam int REQ_DATA_W   = 144;
   localparam int RSP_DATA_W   = 120;
   localparam int ONE_Q14      = 16384;
   localparam int SMALL_LIMIT  = 65536;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 16;
   localparam int CNT_W        = 6;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_SQ   = 6'b000100,
      ST_SQRT = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic [1:0] mul_comp;
      logic       acc_en;
      logic [1:0] acc_comp;
      logic       sq_en;
      logic [1:0] sq_comp;
      logic       sq_add_en;
      logic [1:0] sq_add_comp;
      logic       sq_first;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_done;
      logic [1:0] div_comp;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic near_zero;
   } status_type;

endpackage

[design/mtvb_ctrl.sv]
// Sequencer of the morph target vertex blender: handshakes, step counting and commands.
module mtvb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_mode,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mtvb_pkg::status_type sts,
   output mtvb_pkg::cmd_type    cmd
);
   import mtvb_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       comp_ff, comp_in;
   logic             vld_ff, vld_in;
   logic [CNT_W-1:0] cnt_m1;

   assign cnt_m1     = cnt_ff - CNT_W'(1);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = vld_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               if (req_mode) state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en   = (cnt_ff < CNT_W'(3));
            cmd.mul_comp = cnt_ff[1:0];
            cmd.acc_en   = (cnt_ff != '0);
            cmd.acc_comp = cnt_m1[1:0];
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = sts.last ? ST_SQ : ST_IDLE;
            end
         end
         ST_SQ: begin
            cmd.sq_en       = (cnt_ff < CNT_W'(3));
            cmd.sq_comp     = cnt_ff[1:0];
            cmd.sq_add_en   = (cnt_ff != '0);
            cmd.sq_add_comp = cnt_m1[1:0];
            cmd.sq_first    = (cnt_ff == CNT_W'(1));
            cnt_in          = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == '0) begin
               if (sts.near_zero) begin
                  state_in = ST_OUT;
               end else begin
                  cmd.sqrt_init = 1'b1;
               end
            end else begin
               cmd.sqrt_step = 1'b1;
               if (cnt_ff == CNT_W'(SQRT_STEPS)) begin
                  cnt_in   = '0;
                  comp_in  = 2'd0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_comp = comp_ff;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == '0) begin
               cmd.div_init = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS)) begin
                  cmd.div_done = 1'b1;
                  cnt_in       = '0;
                  comp_in      = comp_ff + 2'd1;
                  if (comp_ff == 2'd2) state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!vld_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      if (cmd.out_load) vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         comp_ff  <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
         vld_ff   <= vld_in;
      end
   end

   // A new result is loaded only when the output register is free or being emptied.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!vld_ff || rsp_tready))
      else $error("result loaded over a waiting beat");

   // A vertex contribution is always followed by the multiply pass.
   a_mul_after: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_mode) |=> (state_ff == ST_MUL))
      else $error("multiply pass skipped");

   // The root and the divider never run together.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sqrt_step && cmd.div_step))
      else $error("root and divider overlap");

endmodule

[design/mtvb_dp.sv]
// Datapath of the morph target vertex blender: weights, accumulators, root, divider, output.
module mtvb_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  mtvb_pkg::cmd_type                   cmd,
   input  logic [mtvb_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output mtvb_pkg::status_type                sts,
   output logic [mtvb_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import mtvb_pkg::*;

   logic [TGT_W-1:0]        in_tgt;
   logic signed [15:0]      in_wt;
   logic [IDX_W-1:0]        in_idx;
   logic                    tgt_ok;

   logic signed [15:0]      table_ff [TARGET_COUNT];
   logic signed [WSUM_W-1:0] wsum_ff, wsum_in;
   logic signed [15:0]      base_ff;
   logic signed [WSUM_W:0]  base_full;

   logic signed [15:0]      w_ff;
   logic                    add_ok_ff, tgt0_ff, last_ff;
   logic signed [23:0]      pos_ff [3];
   logic signed [15:0]      nrm_ff [3];

   logic signed [39:0]      pprod_ff;
   logic signed [31:0]      nprod_ff;
   logic signed [39:0]      psum_ff [3];
   logic signed [31:0]      nsum_ff [3];
   logic signed [40:0]      padd;
   logic signed [32:0]      nadd;

   logic [31:0]             sq_abs;
   logic [63:0]             sq_ff, s_ff;

   logic [63:0]             ss_ff, r_ff, bit_ff, rb;

   logic [31:0]             d_abs;
   logic [46:0]             dvd;
   logic [46:0]             rem_ff;
   logic [47:0]             dv_ff;
   logic [15:0]             q_ff, q_in;
   logic                    sat_ff, neg_ff, ge;
   logic [15:0]             qf;
   logic [16:0]             mag;
   logic [16:0]             res;
   logic signed [15:0]      nq_ff [3];

   logic signed [40:0]      pround [3];
   logic signed [26:0]      pshift [3];
   logic signed [23:0]      pout [3];
   logic [RSP_DATA_W-1:0]   out_ff;

   assign in_tgt = req_tdata[3:0];
   assign in_wt  = req_tdata[19:4];
   assign in_idx = IDX_W'(in_tgt);
   assign tgt_ok = (32'(in_tgt) < TARGET_COUNT);

   assign sts.last      = last_ff;
   assign sts.near_zero = (s_ff <= 64'(SMALL_LIMIT));

   // Weight table with a running sum; the base weight follows every write.
   always_comb begin
      wsum_in   = wsum_ff - WSUM_W'(table_ff[in_idx]) + WSUM_W'(in_wt);
      base_full = (WSUM_W + 1)'(ONE_Q14) - (WSUM_W + 1)'(wsum_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TARGET_COUNT; i++) table_ff[i] <= '0;
         wsum_ff <= '0;
         base_ff <= 16'(ONE_Q14);
      end else if (cmd.capture && !req_tuser && in_tgt != '0 && tgt_ok) begin
         table_ff[in_idx] <= in_wt;
         wsum_ff          <= wsum_in;
         if (base_full > 32767)       base_ff <= 16'sh7FFF;
         else if (base_full < -32768) base_ff <= 16'sh8000;
         else                         base_ff <= base_full[15:0];
      end
   end

   // Captured item.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (cmd.capture) begin
         last_ff <= req_tuser && req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tgt0_ff <= (in_tgt == '0);
         if (in_tgt == '0) begin
            w_ff      <= base_ff;
            add_ok_ff <= 1'b1;
         end else if (tgt_ok) begin
            w_ff      <= table_ff[in_idx];
            add_ok_ff <= (table_ff[in_idx] > 0);
         end else begin
            w_ff      <= '0;
            add_ok_ff <= 1'b0;
         end
         pos_ff[0] <= req_tdata[43:20];
         pos_ff[1] <= req_tdata[67:44];
         pos_ff[2] <= req_tdata[91:68];
         nrm_ff[0] <= req_tdata[107:92];
         nrm_ff[1] <= req_tdata[123:108];
         nrm_ff[2] <= req_tdata[139:124];
      end
   end

   // One component a cycle: multiply, then accumulate with saturation.
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         pprod_ff <= w_ff * pos_ff[cmd.mul_comp];
         nprod_ff <= w_ff * nrm_ff[cmd.mul_comp];
      end
   end

   assign padd = 41'(psum_ff[cmd.acc_comp]) + 41'(pprod_ff);
   assign nadd = 33'(nsum_ff[cmd.acc_comp]) + 33'(nprod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            psum_ff[i] <= '0;
            nsum_ff[i] <= '0;
         end
      end else if (cmd.acc_en) begin
         if (tgt0_ff) begin
            psum_ff[cmd.acc_comp] <= pprod_ff;
            nsum_ff[cmd.acc_comp] <= nprod_ff;
         end else if (add_ok_ff) begin
            if (padd > 41'sh7F_FFFF_FFFF)       psum_ff[cmd.acc_comp] <= 40'sh7F_FFFF_FFFF;
            else if (padd < -41'sh80_0000_0000) psum_ff[cmd.acc_comp] <= 40'sh80_0000_0000;
            else                                psum_ff[cmd.acc_comp] <= padd[39:0];
            if (nadd > 33'sh7FFF_FFFF)          nsum_ff[cmd.acc_comp] <= 32'sh7FFF_FFFF;
            else if (nadd < -33'sh8000_0000)    nsum_ff[cmd.acc_comp] <= 32'sh8000_0000;
            else                                nsum_ff[cmd.acc_comp] <= nadd[31:0];
         end
      end
   end

   // Squared length of the normal sum.
   assign sq_abs = nsum_ff[cmd.sq_comp][31] ? 32'(-nsum_ff[cmd.sq_comp])
                                            : 32'(nsum_ff[cmd.sq_comp]);

   always_ff @(posedge clock) begin
      if (cmd.sq_en) sq_ff <= 64'(sq_abs) * 64'(sq_abs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
      end else if (cmd.sq_add_en) begin
         s_ff <= cmd.sq_first ? sq_ff : s_ff + sq_ff;
      end
   end

   // Integer square root, two radicand bits a step.
   assign rb = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         ss_ff  <= s_ff;
         r_ff   <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (cmd.sqrt_step) begin
         if (ss_ff >= rb) begin
            ss_ff <= ss_ff - rb;
            r_ff  <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff  <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Restoring divider, one quotient bit a step; large quotients saturate at once.
   assign d_abs = nsum_ff[cmd.div_comp][31] ? 32'(-nsum_ff[cmd.div_comp])
                                            : 32'(nsum_ff[cmd.div_comp]);
   assign dvd   = {1'b0, d_abs, 14'b0} + 47'(r_ff[32:1]);
   assign ge    = ({1'b0, rem_ff} >= dv_ff);
   assign q_in  = {q_ff[14:0], ge};

   always_comb begin
      qf  = sat_ff ? 16'hFFFF : q_in;
      if (neg_ff) mag = (qf > 16'd32768) ? 17'd32768 : {1'b0, qf};
      else        mag = (qf > 16'd32767) ? 17'd32767 : {1'b0, qf};
      res = neg_ff ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= dvd;
         dv_ff  <= {r_ff[32:0], 15'b0};
         sat_ff <= ({2'b0, dvd} >= {r_ff[32:0], 16'b0});
         neg_ff <= nsum_ff[cmd.div_comp][31];
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (ge) rem_ff <= rem_ff - dv_ff[46:0];
         dv_ff <= dv_ff >> 1;
         q_ff  <= q_in;
         if (cmd.div_done) nq_ff[cmd.div_comp] <= res[15:0];
      end
   end

   // Rounded and saturated position, and the output register.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pround[i] = 41'(psum_ff[i]) + 41'sd8192;
         pshift[i] = pround[i][40:14];
         if (pshift[i] > 27'sd8388607)       pout[i] = 24'sh7FFFFF;
         else if (pshift[i] < -27'sd8388608) pout[i] = 24'sh800000;
         else                                pout[i] = pshift[i][23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff[23:0]  <= pout[0];
         out_ff[47:24] <= pout[1];
         out_ff[71:48] <= pout[2];
         if (sts.near_zero) begin
            out_ff[119:72] <= '0;
         end else begin
            out_ff[87:72]   <= nq_ff[0];
            out_ff[103:88]  <= nq_ff[1];
            out_ff[119:104] <= nq_ff[2];
         end
      end
   end

   assign rsp_tdata = out_ff;

endmodule

[design/morph_target_vertex_blend.sv]
// Top level of the morph target vertex blender.
// The block blends one vertex from up to TARGET_COUNT morph targets. A beat with tuser low
// stores the Q2.14 weight of a target from 1 upwards; the base target 0 always carries one
// minus the sum of those weights, saturated. A beat with tuser high brings one target's
// Q16.8 position and Q2.14 normal: target 0 loads the accumulators, any later target adds
// only when its weight is positive, and every sum saturates. When such a beat has tlast
// set, one result beat follows with the rounded blended position and the unit-length
// normal (zero when the normal sum is nearly zero). A vertex contribution runs the three
// components through a single shared multiplier pair. The closing contribution then
// computes the squared length, runs the bit-serial square root and the bit-serial divider
// over the three components and loads the result; with a nearly zero normal the root and
// the divider are skipped. A finished result waits in an output register, so the next beat
// is taken while it is still unread; a further closing contribution then holds the block
// until that result has been taken.
module morph_target_vertex_blend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // target[3:0], weight[19:4], pos_x[43:20], pos_y[67:44], pos_z[91:68],
   // nrm_x[107:92], nrm_y[123:108], nrm_z[139:124], zero padding[143:140]
   input  logic [mtvb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode[0]
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_pos_x[23:0], out_pos_y[47:24], out_pos_z[71:48],
   // out_nrm_x[87:72], out_nrm_y[103:88], out_nrm_z[119:104]
   output logic [mtvb_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import mtvb_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // The sequencer owns both handshakes and steps the datapath through each pass.
   mtvb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the weights, accumulators, root and divider units.
   mtvb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule
